@@ sv/bcdc_pkg.sv @@
package bcdc_pkg;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned CountWidth = 14;
  localparam int unsigned CfgIdxWidth = 8;

  localparam logic [CountWidth-1:0] CountMax     = 14'd9999;
  localparam logic [TimerWidth-1:0] DebounceRst  = 16'd5;
  localparam logic [TimerWidth-1:0] ScanTicksRst = 16'd5;

  localparam logic [CfgIdxWidth-1:0] CfgDebounce  = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgScanTicks = 8'd1;

  typedef enum logic [1:0] {
    PhaseIdle     = 2'd0,
    PhaseDebounce = 2'd1,
    PhaseHeld     = 2'd2
  } phase_e;

  typedef struct packed {
    logic up;
    logic dn;
  } step_t;

  typedef struct packed {
    logic [7:0]            segments_n;
    logic [NumDigits-1:0]  digit_enable_n;
    logic [CountWidth-1:0] count_value;
  } result_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hc0;
      4'd1:    seg = 8'hf9;
      4'd2:    seg = 8'ha4;
      4'd3:    seg = 8'hb0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hf8;
      4'd8:    seg = 8'h80;
      default: seg = 8'h90;
    endcase
    return seg;
  endfunction

  function automatic logic [TimerWidth-1:0] at_least_one(input logic [TimerWidth-1:0] v);
    return (v == '0) ? {{(TimerWidth-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

@@ sv/bcdc_press.sv @@
module bcdc_press (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  logic                                 up_button_n_i,
  input  logic                                 down_button_n_i,
  input  logic [bcdc_pkg::TimerWidth-1:0]      debounce_ticks_i,
  output bcdc_pkg::step_t                      step_o
);

  bcdc_pkg::phase_e                  phase_q, phase_d;
  logic                              is_down_q, is_down_d;
  logic [bcdc_pkg::TimerWidth-1:0]   timer_q, timer_d;
  logic [bcdc_pkg::TimerWidth-1:0]   timer_inc;
  logic [bcdc_pkg::TimerWidth-1:0]   limit;
  logic                              up_low, dn_low, tracked_low;

  assign up_low      = ~up_button_n_i;
  assign dn_low      = ~down_button_n_i;
  assign tracked_low = is_down_q ? dn_low : up_low;
  assign limit       = bcdc_pkg::at_least_one(debounce_ticks_i);
  assign timer_inc   = timer_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    is_down_d = is_down_q;
    timer_d   = timer_q;
    unique case (phase_q)
      bcdc_pkg::PhaseDebounce: begin
        if (timer_inc >= limit) begin
          timer_d = '0;
          phase_d = tracked_low ? bcdc_pkg::PhaseHeld : bcdc_pkg::PhaseIdle;
        end else begin
          timer_d = timer_inc;
        end
      end
      bcdc_pkg::PhaseHeld: begin
        if (!tracked_low) begin
          phase_d = bcdc_pkg::PhaseIdle;
          timer_d = '0;
        end
      end
      default: begin
        phase_d = bcdc_pkg::PhaseIdle;
        if (up_low) begin
          phase_d   = bcdc_pkg::PhaseDebounce;
          is_down_d = 1'b0;
          timer_d   = '0;
        end else if (dn_low) begin
          phase_d   = bcdc_pkg::PhaseDebounce;
          is_down_d = 1'b1;
          timer_d   = '0;
        end
      end
    endcase
  end

  always_comb begin
    step_o = '0;
    if (fire_i && phase_q == bcdc_pkg::PhaseHeld && !tracked_low) begin
      step_o.up = ~is_down_q;
      step_o.dn = is_down_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bcdc_pkg::PhaseIdle;
      is_down_q <= 1'b0;
      timer_q   <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      is_down_q <= is_down_d;
      timer_q   <= timer_d;
    end
  end

endmodule

@@ sv/bcdc_digit_cell.sv @@
module bcdc_digit_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bcdc_pkg::step_t carry_i,
  output bcdc_pkg::step_t carry_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q, digit_d;

  always_comb begin
    digit_d = digit_q;
    if (carry_i.up) begin
      digit_d = (digit_q >= 4'd9) ? 4'd0 : digit_q + 4'd1;
    end else if (carry_i.dn) begin
      digit_d = (digit_q == 4'd0) ? 4'd9 : digit_q - 4'd1;
    end
  end

  assign carry_o.up = carry_i.up & (digit_q >= 4'd9);
  assign carry_o.dn = carry_i.dn & (digit_q == 4'd0);
  assign digit_o    = digit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ sv/bcdc_out_buf.sv @@
module bcdc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  bcdc_pkg::result_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output bcdc_pkg::result_t pop_data_o
);

  logic [1:0]        fill_q, fill_d;
  bcdc_pkg::result_t head_q, head_d, tail_q, tail_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = head_q;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    tail_d = tail_q;
    case (fill_q)
      2'd0: begin
        if (push) begin
          head_d = push_data_i;
          fill_d = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_d = push_data_i;
        end else if (push) begin
          tail_d = push_data_i;
          fill_d = 2'd2;
        end else if (pop) begin
          fill_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_d = tail_q;
          fill_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

@@ sv/bcd_updown_counter_seven_segment.sv @@
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_ready_o     up_button_n_i, down_button_n_i
// out       out        out_valid_o/out_ready_i   segments_n_o, digit_enable_n_o, count_value_o
//
// One item per clock cycle while in_ready_o is high; its result is registered in the output buffer.
// The count is held as a row of four BCD digit cells with a carry chain between them.
// A two-entry output buffer keeps input ready high while one result waits downstream.
// Reset clears the count, the press tracker, the scan position and the buffer.
// Configuration writes are taken on every cycle.
module bcd_updown_counter_seven_segment (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bcdc_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [bcdc_pkg::TimerWidth-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  up_button_n_i,
  input  logic                                  down_button_n_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [7:0]                            segments_n_o,
  output logic [bcdc_pkg::NumDigits-1:0]        digit_enable_n_o,
  output logic [bcdc_pkg::CountWidth-1:0]       count_value_o
);

  logic [bcdc_pkg::TimerWidth-1:0] debounce_q, scan_ticks_q;
  logic [bcdc_pkg::TimerWidth-1:0] scan_timer_q, scan_timer_d, scan_inc, scan_limit;
  logic [1:0]                      scan_digit_q, scan_digit_d;
  logic [bcdc_pkg::CountWidth-1:0] count_q, count_d;
  logic                            fire;
  bcdc_pkg::step_t                 step;
  bcdc_pkg::step_t                 carry [bcdc_pkg::NumDigits+1];
  logic [3:0]                      digit [bcdc_pkg::NumDigits];
  bcdc_pkg::result_t               res, res_out;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bcdc_pkg::DebounceRst;
      scan_ticks_q <= bcdc_pkg::ScanTicksRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bcdc_pkg::CfgDebounce:  debounce_q   <= cfg_data_i;
        bcdc_pkg::CfgScanTicks: scan_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcdc_press u_press (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .up_button_n_i    (up_button_n_i),
    .down_button_n_i  (down_button_n_i),
    .debounce_ticks_i (debounce_q),
    .step_o           (step)
  );

  // The ones digit sits at the highest position, so the carry runs downward.
  assign carry[bcdc_pkg::NumDigits] = step;

  for (genvar g = 0; g < bcdc_pkg::NumDigits; g++) begin : g_cell
    bcdc_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .carry_i (carry[g+1]),
      .carry_o (carry[g]),
      .digit_o (digit[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (step.up) begin
      count_d = (count_q >= bcdc_pkg::CountMax) ? '0 : count_q + 14'd1;
    end else if (step.dn) begin
      count_d = (count_q == '0) ? bcdc_pkg::CountMax : count_q - 14'd1;
    end
  end

  assign scan_limit = bcdc_pkg::at_least_one(scan_ticks_q);
  assign scan_inc   = scan_timer_q + 16'd1;

  always_comb begin
    scan_timer_d = scan_inc;
    scan_digit_d = scan_digit_q;
    if (scan_inc >= scan_limit) begin
      scan_timer_d = '0;
      scan_digit_d = scan_digit_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      scan_timer_q <= '0;
      scan_digit_q <= 2'd0;
    end else if (fire) begin
      count_q      <= count_d;
      scan_timer_q <= scan_timer_d;
      scan_digit_q <= scan_digit_d;
    end
  end

  assign res.segments_n     = bcdc_pkg::seg_of(digit[scan_digit_q]);
  assign res.digit_enable_n = ~(4'b0001 << scan_digit_q);
  assign res.count_value    = count_d;

  bcdc_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (res),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (res_out)
  );

  assign segments_n_o     = res_out.segments_n;
  assign digit_enable_n_o = res_out.digit_enable_n;
  assign count_value_o    = res_out.count_value;

endmodule

@@ sv/bcdc_checker.sv @@
module bcdc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [7:0]                            segments_n_o,
  input logic [bcdc_pkg::NumDigits-1:0]        digit_enable_n_o,
  input logic [bcdc_pkg::CountWidth-1:0]       count_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_value_o))
    else $error("An item left the output without being taken.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_value_o <= bcdc_pkg::CountMax)
    else $error("Count left the decimal range.");

  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~digit_enable_n_o) && segments_n_o[7])
    else $error("Display drives other than one digit, or the decimal point.");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input stalled while no result waits.");

endmodule

bind bcd_updown_counter_seven_segment bcdc_checker u_bcdc_checker (.*);
